// ===== sv/bpcg_pkg.sv =====
// Shared types, constants and the PCG32 output function for the bounded
// PCG32 random source. No dependencies.
`default_nettype none

package bpcg_pkg;

	// Generator seed and LCG constants
	localparam logic [63:0] SEED_VALUE = 64'h853c_49e6_748f_ea9b;
	localparam logic [63:0] LCG_INC    = 64'hda3e_39cb_94b9_5bdb;
	localparam logic [63:0] LCG_MUL    = 64'h5851_f42d_4c95_7f2d;

	// Remainder steps for the rejection threshold
	localparam int DIV_STEPS = 32;

	// Request class decided by the front
	typedef enum logic [1:0] {
		OP_RAW,
		OP_BOUND,
		OP_ZERO
	} op_t;

	// Queue entry between front and back
	typedef struct packed {
		op_t         op;
		logic [31:0] limit;
	} item_t;

	// Back-end sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_LO,
		ST_MUL_X1,
		ST_MUL_X2,
		ST_ADVANCE,
		ST_BOUND_MUL,
		ST_CHECK,
		ST_DIVIDE
	} back_state_t;

	// XSH-RR output word taken from the old generator state
	function automatic logic [31:0] xsh_rr(input logic [63:0] s);
		logic [63:0] t;
		logic [31:0] x;
		logic [63:0] dbl;
		t   = ((s >> 18) ^ s) >> 27;
		x   = t[31:0];
		dbl = {x, x} >> s[63:59];
		return dbl[31:0];
	endfunction

endpackage

`default_nettype wire

// ===== sv/bounded_pcg32_random.sv =====
// Bounded PCG32 random source, top level: front end, request queue and
// back end. Depends on bpcg_pkg, bpcg_front, bpcg_fifo and bpcg_back.
//
// Usage: each request on the req channel (mode, limit) yields exactly one
// value on the rsp channel, in request order. Mode 0 returns a raw 32-bit
// XSH-RR word; mode 1 returns an unbiased value below limit (0 when limit
// is 0, after one generator advance).
// Path: a raw or zero-limit request passes the front register, the queue
// and the back-end states MUL_LO, MUL_X1, MUL_X2, ADVANCE and CHECK before
// the response register. A bounded request adds BOUND_MUL for the product,
// the serial remainder whenever the first product's low half is below
// limit, and another pass from MUL_LO per redraw.
// The back end works on one item at a time and takes a new one only once
// back in ST_IDLE; it has a shared 32x32 multiplier (three passes per
// advance, one more for the bound) and a one-bit-per-cycle remainder unit.
// Reset: the generator returns to its fixed seed and all queued requests
// are dropped. A stalled receiver holds the response register; the queue
// and front register keep taking requests until they fill.
`default_nettype none

module bounded_pcg32_random #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         req_valid,
	output logic        req_ready,
	input  wire         mode,
	input  wire  [31:0] limit,
	output logic        rsp_valid,
	input  wire         rsp_ready,
	output logic [31:0] value
);
	import bpcg_pkg::*;

	logic  fr_valid;
	logic  fr_ready;
	item_t fr_item;
	logic  q_valid;
	logic  q_ready;
	item_t q_item;

	// Register and classify requests
	bpcg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.mode       (mode),
		.limit      (limit),
		.item_valid (fr_valid),
		.item_ready (fr_ready),
		.item       (fr_item)
	);

	// Decouple front from back
	bpcg_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fr_valid),
		.wr_ready (fr_ready),
		.wr_item  (fr_item),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_item  (q_item)
	);

	// Draw, bound and deliver
	bpcg_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (q_valid),
		.item_ready (q_ready),
		.item       (q_item),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.value      (value)
	);

endmodule

`default_nettype wire

// ===== sv/bpcg_front.sv =====
// Request front end: registers incoming requests and classifies them.
// Depends on bpcg_pkg.
`default_nettype none

module bpcg_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	output logic                req_ready,
	input  wire                 mode,
	input  wire  [31:0]         limit,
	output logic                item_valid,
	input  wire                 item_ready,
	output bpcg_pkg::item_t     item
);
	import bpcg_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	logic  push;
	logic  take;

	assign push       = valid_s1 && item_ready;
	assign req_ready  = !valid_s1 || item_ready;
	assign take       = req_valid && req_ready;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	// Hold one request until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// Classify: raw word, bounded draw, or zero limit (one advance, value 0)
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.limit <= limit;
			if (!mode) begin
				item_s1.op <= OP_RAW;
			end else if (limit == 32'd0) begin
				item_s1.op <= OP_ZERO;
			end else begin
				item_s1.op <= OP_BOUND;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/bpcg_fifo.sv =====
// Short queue of classified requests between front and back end.
// Depends on bpcg_pkg.
`default_nettype none

module bpcg_fifo #(
	parameter int DEPTH = 2
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 wr_valid,
	output logic                wr_ready,
	input  bpcg_pkg::item_t     wr_item,
	output logic                rd_valid,
	input  wire                 rd_ready,
	output bpcg_pkg::item_t     rd_item
);
	import bpcg_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t            mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign wr_ready = count_q != CNT_W'(DEPTH);
	assign rd_valid = count_q != '0;
	assign rd_item  = mem[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wrap_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= wrap_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_item;
		end
	end

endmodule

`default_nettype wire

// ===== sv/bpcg_back.sv =====
// Back end: PCG32 generator, shared 32x32 multiplier, serial remainder
// unit for the rejection threshold, and the result register. Uses bpcg_pkg.
`default_nettype none

module bpcg_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 item_valid,
	output logic                item_ready,
	input  bpcg_pkg::item_t     item,
	output logic                rsp_valid,
	input  wire                 rsp_ready,
	output logic [31:0]         value
);
	import bpcg_pkg::*;

	back_state_t state_q;
	back_state_t state_d;

	logic [63:0] gen_q;
	logic [63:0] acc_q;
	logic [31:0] word_q;
	op_t         op_q;
	logic [31:0] limit_q;
	logic [63:0] p_q;
	logic [31:0] thr_q;
	logic        thr_valid_q;
	logic [31:0] rem_q;
	logic [31:0] dvd_q;
	logic [4:0]  cnt_q;
	logic        rsp_valid_q;
	logic [31:0] value_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mul_prod;
	logic        out_free;
	logic        emit;
	logic [31:0] emit_val;
	logic        div_start;
	logic        div_last;
	logic [32:0] trial;
	logic [31:0] rem_next;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign value     = value_q;
	assign div_last  = cnt_q == 5'(DIV_STEPS - 1);

	// Shared multiplier operand select
	always_comb begin
		mul_a = gen_q[31:0];
		mul_b = LCG_MUL[31:0];
		case (state_q)
			ST_MUL_X1: begin
				mul_a = gen_q[63:32];
				mul_b = LCG_MUL[31:0];
			end
			ST_MUL_X2: begin
				mul_a = gen_q[31:0];
				mul_b = LCG_MUL[63:32];
			end
			ST_BOUND_MUL: begin
				mul_a = word_q;
				mul_b = limit_q;
			end
			default: begin
				mul_a = gen_q[31:0];
				mul_b = LCG_MUL[31:0];
			end
		endcase
	end

	assign mul_prod = {32'd0, mul_a} * {32'd0, mul_b};

	// One restoring remainder step
	assign trial    = {rem_q, dvd_q[31]};
	assign rem_next = (trial >= {1'b0, limit_q}) ? 32'(trial - {1'b0, limit_q})
	                                             : trial[31:0];

	// Result word for the current item
	always_comb begin
		case (op_q)
			OP_RAW:   emit_val = word_q;
			OP_BOUND: emit_val = p_q[63:32];
			default:  emit_val = 32'd0;
		endcase
	end

	// Sequencer: next state and strobes
	always_comb begin
		state_d    = state_q;
		item_ready = 1'b0;
		emit       = 1'b0;
		div_start  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					state_d = ST_MUL_LO;
				end
			end
			ST_MUL_LO:  state_d = ST_MUL_X1;
			ST_MUL_X1:  state_d = ST_MUL_X2;
			ST_MUL_X2:  state_d = ST_ADVANCE;
			ST_ADVANCE: state_d = (op_q == OP_BOUND) ? ST_BOUND_MUL : ST_CHECK;
			ST_BOUND_MUL: state_d = ST_CHECK;
			ST_CHECK: begin
				if (op_q == OP_BOUND && !thr_valid_q && p_q[31:0] < limit_q) begin
					div_start = 1'b1;
					state_d   = ST_DIVIDE;
				end else if (op_q == OP_BOUND && thr_valid_q && p_q[31:0] < thr_q) begin
					state_d = ST_MUL_LO;
				end else if (out_free) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_DIVIDE: begin
				if (div_last) begin
					state_d = ST_CHECK;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control state, generator state, threshold valid and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			gen_q       <= SEED_VALUE;
			thr_valid_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_ADVANCE) begin
				gen_q <= acc_q + LCG_INC;
			end
			if (item_ready && item_valid) begin
				thr_valid_q <= 1'b0;
			end else if (state_q == ST_DIVIDE && div_last) begin
				thr_valid_q <= 1'b1;
			end
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			op_q    <= item.op;
			limit_q <= item.limit;
		end
		case (state_q)
			ST_MUL_LO: begin
				word_q <= xsh_rr(gen_q);
				acc_q  <= mul_prod;
			end
			ST_MUL_X1, ST_MUL_X2: begin
				acc_q[63:32] <= acc_q[63:32] + mul_prod[31:0];
			end
			ST_BOUND_MUL: begin
				p_q <= mul_prod;
			end
			ST_DIVIDE: begin
				rem_q <= rem_next;
				dvd_q <= dvd_q << 1;
				cnt_q <= cnt_q + 5'd1;
				if (div_last) begin
					thr_q <= rem_next;
				end
			end
			default: begin
			end
		endcase
		if (div_start) begin
			rem_q <= 32'd0;
			dvd_q <= 32'd0 - limit_q;
			cnt_q <= 5'd0;
		end
		if (emit) begin
			value_q <= emit_val;
		end
	end

	a_thr_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		thr_valid_q |-> (thr_q < limit_q))
		else $error("rejection threshold not below limit");

	a_divide_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIVIDE) |-> (limit_q != 32'd0))
		else $error("threshold remainder started with zero limit");

	a_bounded_result: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && op_q == OP_BOUND) |=> (value_q < limit_q))
		else $error("bounded result not below limit");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Testbench for bounded_pcg32_random: a directed and random request stream,
// with every value checked against a PCG32 XSH-RR / Lemire bounded predictor.
// Depends only on the RTL (the bounded_pcg32_random top level and, through it, bpcg_pkg).
`timescale 1ns / 100ps

module tb;

	// Request modes as seen on the mode port
	localparam logic MODE_RAW   = 1'b0;
	localparam logic MODE_BOUND = 1'b1;

	// Generator seed and LCG step
	localparam logic [63:0] PCG_SEED = 64'h853c_49e6_748f_ea9b;
	localparam logic [63:0] PCG_MUL  = 64'd6364136223846793005;
	localparam logic [63:0] PCG_INC  = 64'hda3e_39cb_94b9_5bdb;

	localparam int RANDOM_REQS = 400;
	localparam int DRAIN_WAIT  = 60;

	typedef struct {
		logic        mode;
		logic [31:0] limit;
		bit          drain;
	} draw_req_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	logic        mode      = MODE_RAW;
	logic [31:0] limit     = '0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	logic [31:0] value;

	draw_req_t   pending_reqs[$];
	logic [31:0] expected_values[$];
	logic [63:0] gen_state = PCG_SEED;
	int          errors    = 0;
	bit          req_fire  = 1'b0;
	int          burst_left = 4;
	int          gap_left   = 0;
	logic [15:0] stall_pat  = 16'hffff;
	int          stall_age  = 0;

	bounded_pcg32_random u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.mode      (mode),
		.limit     (limit),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.value     (value)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Advance the generator one LCG step and return the XSH-RR word of the old state
	function automatic logic [31:0] pcg_next_word();
		logic [63:0] s;
		logic [63:0] mixed;
		logic [31:0] x;
		logic [5:0]  rr;
		s         = gen_state;
		gen_state = s * PCG_MUL + PCG_INC;
		mixed     = ((s >> 18) ^ s) >> 27;
		x         = mixed[31:0];
		rr        = {1'b0, s[63:59]};
		return (x >> rr) | (x << (6'd32 - rr));
	endfunction

	// Lemire multiply-and-reject: unbiased value below lim, zero for a zero limit
	function automatic logic [31:0] bounded_draw(input logic [31:0] lim);
		logic [63:0] prod;
		logic [31:0] thr;
		prod = {32'd0, pcg_next_word()} * {32'd0, lim};
		if (prod[31:0] < lim) begin
			thr = (32'd0 - lim) % lim;
			while (prod[31:0] < thr)
				prod = {32'd0, pcg_next_word()} * {32'd0, lim};
		end
		return prod[63:32];
	endfunction

	function automatic logic [31:0] predict_value(input logic m, input logic [31:0] lim);
		if (m == MODE_RAW)
			return pcg_next_word();
		return bounded_draw(lim);
	endfunction

	// Spread limits over small, huge, rejection-heavy, power-of-two and fully random values
	function automatic logic [31:0] pick_limit();
		case ($urandom_range(0, 7))
			0: return $urandom_range(0, 15);
			1: return 32'hffff_ffff - $urandom_range(0, 15);
			2: return 32'h8000_0000 + $urandom_range(0, 15);
			3: return 32'd1 << $urandom_range(0, 31);
			default: return $urandom;
		endcase
	endfunction

	task automatic add_req(input logic m, input logic [31:0] lim, input bit drain);
		draw_req_t r;
		r.mode  = m;
		r.limit = lim;
		r.drain = drain;
		pending_reqs.push_back(r);
	endtask

	// Sample transfers, predict on each request and check each response
	always @(posedge clk) begin
		logic [31:0] want;
		req_fire = arst_n && req_valid && req_ready;
		if (req_fire)
			expected_values.push_back(predict_value(mode, limit));
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_values.size() == 0) begin
				$error("unexpected response: value %h", value);
				errors++;
			end else begin
				want = expected_values.pop_front();
				if (value !== want) begin
					$error("value mismatch: expected %h, actual %h", want, value);
					errors++;
				end
			end
		end
	end

	// Drive requests in bursts with random gaps; hold each until its transfer
	always @(negedge clk) begin
		bit          nxt_valid;
		logic        nxt_mode;
		logic [31:0] nxt_limit;
		nxt_valid = req_valid;
		nxt_mode  = mode;
		nxt_limit = limit;
		if (arst_n && (!req_valid || req_fire)) begin
			if (req_fire)
				void'(pending_reqs.pop_front());
			nxt_valid = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_reqs.size() > 0 &&
					!(pending_reqs[0].drain && expected_values.size() > 0)) begin
				nxt_valid = 1'b1;
				nxt_mode  = pending_reqs[0].mode;
				nxt_limit = pending_reqs[0].limit;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 12);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
				end
			end
		end
		req_valid <= nxt_valid;
		mode      <= nxt_mode;
		limit     <= nxt_limit;
	end

	// Stall the response side on a rotating pattern, re-picked now and then
	always @(negedge clk) begin
		stall_age++;
		if (stall_age >= 150) begin
			stall_age = 0;
			case ($urandom_range(0, 2))
				0: stall_pat = 16'hffff;
				1: stall_pat = 16'($urandom);
				default: stall_pat = 16'($urandom | $urandom);
			endcase
		end
		stall_pat = {stall_pat[14:0], stall_pat[15]};
		rsp_ready <= arst_n && stall_pat[15];
	end

	initial begin
		// Field extremes, both modes, zero limit, rejection-heavy limits
		add_req(MODE_RAW,   32'h0000_0000, 1'b0);
		add_req(MODE_RAW,   32'hffff_ffff, 1'b0);
		add_req(MODE_RAW,   32'haaaa_aaaa, 1'b0);
		add_req(MODE_BOUND, 32'h0000_0000, 1'b0);
		add_req(MODE_BOUND, 32'h0000_0000, 1'b0);
		add_req(MODE_BOUND, 32'h0000_0001, 1'b0);
		add_req(MODE_BOUND, 32'h0000_0002, 1'b0);
		add_req(MODE_BOUND, 32'h0000_0003, 1'b0);
		add_req(MODE_BOUND, 32'hffff_ffff, 1'b0);
		add_req(MODE_BOUND, 32'hffff_fffe, 1'b0);
		add_req(MODE_BOUND, 32'h8000_0000, 1'b0);
		add_req(MODE_BOUND, 32'h8000_0001, 1'b0);
		add_req(MODE_BOUND, 32'h8000_0001, 1'b0);
		add_req(MODE_BOUND, 32'h8000_0001, 1'b0);
		add_req(MODE_BOUND, 32'h7fff_ffff, 1'b0);
		add_req(MODE_BOUND, 32'h5555_5555, 1'b0);
		add_req(MODE_BOUND, 32'haaaa_aaaa, 1'b0);
		add_req(MODE_BOUND, 32'h0001_0001, 1'b0);
		add_req(MODE_RAW,   32'h5555_5555, 1'b0);
		add_req(MODE_BOUND, 32'h0000_0000, 1'b0);

		// Random part; pause for a full drain at its start and halfway
		for (int i = 0; i < RANDOM_REQS; i++)
			add_req(($urandom_range(0, 9) < 3) ? MODE_RAW : MODE_BOUND, pick_limit(),
				i == 0 || i == RANDOM_REQS / 2);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_reqs.size() > 0)
			@(posedge clk);
		while (expected_values.size() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (errors == 0)
			$display("[bounded_pcg32_random] OK");
		else
			$display("[bounded_pcg32_random] ERROR");
		$finish;
	end

	// Hard stop if the run hangs
	initial begin
		#5_000_000;
		$display("[bounded_pcg32_random] ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/bpcg_pkg.sv
sv/bpcg_front.sv
sv/bpcg_fifo.sv
sv/bpcg_back.sv
sv/bounded_pcg32_random.sv
dv/tb.sv
